>>> hw/rtl/kaf_pkg.sv
// ----------------------------------------------------------------------------
// kaf_pkg
// Shared types, codes and fixed-point helpers of the Kalman angle filter.
// ----------------------------------------------------------------------------
package kaf_pkg;

  localparam int MUL_A_W = 35;
  localparam int MUL_B_W = 33;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int RND_W   = 36;
  localparam int ACC_W   = 40;
  localparam int DIV_STEPS = 31;
  localparam int CNT_W   = 5;

  localparam logic [30:0] QA_RESET = 31'd268435;
  localparam logic [30:0] QB_RESET = 31'd805306;
  localparam logic [30:0] R_RESET  = 31'd8053064;

  localparam logic [1:0] REG_QA = 2'd0;
  localparam logic [1:0] REG_QB = 2'd1;
  localparam logic [1:0] REG_R  = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RATE, ST_MUL, ST_RND, ST_WB, ST_INNER, ST_S,
    ST_D0S, ST_D0W, ST_D1S, ST_D1W, ST_Y, ST_OUT
  } state_t;

  typedef enum logic [3:0] {
    OP_ANG, OP_DTP11, OP_P00, OP_P11, OP_KY0, OP_KY1,
    OP_C00, OP_C01, OP_C10, OP_C11
  } op_t;

  typedef struct packed {
    logic load_in;
    logic do_rate;
    logic mul_en;
    logic rnd_en;
    logic wb_en;
    op_t  op;
    logic do_inner;
    logic do_s;
    logic div_start;
    logic div_wait;
    logic div_k1;
    logic do_y;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic s_pos;
  } stat_t;

  localparam logic signed [ACC_W-1:0] SAT_MAX = 40'sd2147483647;
  localparam logic signed [ACC_W-1:0] SAT_MIN = -40'sd2147483648;

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [31:0] r;
    if (v > SAT_MAX) r = 32'sh7fffffff;
    else if (v < SAT_MIN) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  // Shift right by 24 or 28 with rounding to nearest, ties away from zero.
  function automatic logic signed [RND_W-1:0] shr_rnd(input logic signed [PROD_W-1:0] v,
                                                      input logic sel28);
    logic [PROD_W-1:0] mag;
    logic [PROD_W-1:0] sum;
    logic [PROD_W-1:0] sh;
    logic signed [RND_W-1:0] m;
    mag = v[PROD_W-1] ? PROD_W'(-v) : PROD_W'(v);
    sum = mag + (sel28 ? (PROD_W'(1) << 27) : (PROD_W'(1) << 23));
    sh  = sel28 ? (sum >> 28) : (sum >> 24);
    m   = $signed(sh[RND_W-1:0]);
    return v[PROD_W-1] ? -m : m;
  endfunction

endpackage

>>> hw/rtl/kaf_div.sv
// ----------------------------------------------------------------------------
// kaf_div
// Restoring divider for the Kalman gains: (num << 28) / den, truncated toward
// zero and saturated to 32 bits; one quotient bit per cycle.
// ----------------------------------------------------------------------------
module kaf_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [31:0] num,
  input  logic        [31:0] den,
  output logic               done,
  output logic signed [31:0] quot
);

  logic [31:0] rem_r, rem_nxt;
  logic [30:0] bits_r, bits_nxt;
  logic [30:0] q_r, q_nxt;
  logic [31:0] den_r;
  logic        neg_r, ovf_r, busy_r, done_r;
  logic [kaf_pkg::CNT_W-1:0] cnt_r;
  logic [31:0] mag;
  logic [32:0] shv;

  always_comb begin
    mag = num[31] ? 32'(-num) : 32'(num);
    shv = {rem_r, bits_r[30]};
    if (shv >= {1'b0, den_r}) begin
      rem_nxt = 32'(shv - {1'b0, den_r});
      q_nxt   = {q_r[29:0], 1'b1};
    end else begin
      rem_nxt = shv[31:0];
      q_nxt   = {q_r[29:0], 1'b0};
    end
    bits_nxt = {bits_r[29:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= kaf_pkg::CNT_W'(kaf_pkg::DIV_STEPS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == kaf_pkg::CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      // The quotient overflows 31 bits exactly when |num| >= 8 * den.
      rem_r  <= {3'b000, mag[31:3]};
      bits_r <= {mag[2:0], 28'd0};
      q_r    <= '0;
      den_r  <= den;
      neg_r  <= num[31];
      ovf_r  <= {3'b000, mag} >= {den, 3'b000};
    end else if (busy_r) begin
      rem_r  <= rem_nxt;
      bits_r <= bits_nxt;
      q_r    <= q_nxt;
    end
  end

  always_comb begin
    if (ovf_r) quot = neg_r ? 32'sh80000000 : 32'sh7fffffff;
    else quot = neg_r ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});
  end

  assign done = done_r;

endmodule

>>> hw/rtl/kaf_dp.sv
// ----------------------------------------------------------------------------
// kaf_dp
// Datapath: filter state, one shared multiplier with rounding stage, and the
// gain divider.
// ----------------------------------------------------------------------------
module kaf_dp (
  input  logic                  clk,
  input  logic                  rst_n,
  input  kaf_pkg::cmd_t         cmd,
  output kaf_pkg::stat_t        stat,
  input  logic signed [31:0]    in_measured_angle,
  input  logic signed [31:0]    in_measured_rate,
  input  logic        [23:0]    in_time_step,
  input  logic        [30:0]    qa,
  input  logic        [30:0]    qb,
  input  logic        [30:0]    rn,
  output logic signed [31:0]    out_filtered_angle,
  output logic signed [31:0]    out_bias_estimate
);

  logic signed [31:0] ma_r, mr_r, rate_r, y_r, t0_r, t1_r, k0_r, k1_r;
  logic        [23:0] dt_r;
  logic signed [31:0] angle_r, bias_r, p00_r, p01_r, p10_r, p11_r;
  logic signed [32:0] dtp11_r;
  logic signed [34:0] inner_r;
  logic signed [33:0] s_r, s_sum;
  logic signed [kaf_pkg::PROD_W-1:0] prod_r;
  logic signed [kaf_pkg::RND_W-1:0]  rnd_r;
  logic signed [kaf_pkg::MUL_A_W-1:0] mul_a;
  logic signed [kaf_pkg::MUL_B_W-1:0] mul_b, dt_b;
  logic signed [kaf_pkg::ACC_W-1:0]   rnd_x;
  logic sel28;
  logic signed [31:0] div_num, div_q;
  logic div_done;
  logic signed [31:0] out_angle_r, out_bias_r;

  assign dt_b  = $signed({9'd0, dt_r});
  assign rnd_x = kaf_pkg::ACC_W'(rnd_r);
  assign s_sum = 34'(p00_r) + $signed({3'b000, rn});

  always_comb begin
    sel28 = 1'b1;
    mul_a = kaf_pkg::MUL_A_W'(k0_r);
    mul_b = kaf_pkg::MUL_B_W'(y_r);
    case (cmd.op)
      kaf_pkg::OP_ANG: begin
        mul_a = kaf_pkg::MUL_A_W'(rate_r); mul_b = dt_b; sel28 = 1'b0;
      end
      kaf_pkg::OP_DTP11: begin
        mul_a = kaf_pkg::MUL_A_W'(p11_r); mul_b = dt_b; sel28 = 1'b0;
      end
      kaf_pkg::OP_P00: begin
        mul_a = inner_r; mul_b = dt_b; sel28 = 1'b0;
      end
      kaf_pkg::OP_P11: begin
        mul_a = $signed({4'd0, qb}); mul_b = dt_b; sel28 = 1'b0;
      end
      kaf_pkg::OP_KY0: begin
        mul_a = kaf_pkg::MUL_A_W'(k0_r); mul_b = kaf_pkg::MUL_B_W'(y_r);
      end
      kaf_pkg::OP_KY1: begin
        mul_a = kaf_pkg::MUL_A_W'(k1_r); mul_b = kaf_pkg::MUL_B_W'(y_r);
      end
      kaf_pkg::OP_C00: begin
        mul_a = kaf_pkg::MUL_A_W'(k0_r); mul_b = kaf_pkg::MUL_B_W'(t0_r);
      end
      kaf_pkg::OP_C01: begin
        mul_a = kaf_pkg::MUL_A_W'(k0_r); mul_b = kaf_pkg::MUL_B_W'(t1_r);
      end
      kaf_pkg::OP_C10: begin
        mul_a = kaf_pkg::MUL_A_W'(k1_r); mul_b = kaf_pkg::MUL_B_W'(t0_r);
      end
      kaf_pkg::OP_C11: begin
        mul_a = kaf_pkg::MUL_A_W'(k1_r); mul_b = kaf_pkg::MUL_B_W'(t1_r);
      end
      default: begin
        mul_a = kaf_pkg::MUL_A_W'(k0_r); mul_b = kaf_pkg::MUL_B_W'(y_r);
      end
    endcase
  end

  // Item fields and working registers.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      ma_r <= in_measured_angle;
      mr_r <= in_measured_rate;
      dt_r <= in_time_step;
    end
    if (cmd.do_rate) rate_r <= kaf_pkg::sat32(40'(mr_r) - 40'(bias_r));
    if (cmd.mul_en) prod_r <= kaf_pkg::PROD_W'(mul_a) * kaf_pkg::PROD_W'(mul_b);
    if (cmd.rnd_en) rnd_r <= kaf_pkg::shr_rnd(prod_r, sel28);
    if (cmd.wb_en && cmd.op == kaf_pkg::OP_DTP11) dtp11_r <= rnd_r[32:0];
    if (cmd.do_inner) begin
      inner_r <= 35'(dtp11_r) - 35'(p01_r) - 35'(p10_r) + $signed({4'd0, qa});
    end
    if (cmd.do_s) s_r <= s_sum;
    if (cmd.do_y) begin
      y_r  <= kaf_pkg::sat32(40'(ma_r) - 40'(angle_r));
      t0_r <= p00_r;
      t1_r <= p01_r;
    end
    if (cmd.load_out) begin
      out_angle_r <= angle_r;
      out_bias_r  <= bias_r;
    end
  end

  // Filter state and gains.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_r <= '0; bias_r <= '0;
      p00_r <= '0; p01_r <= '0; p10_r <= '0; p11_r <= '0;
      k0_r <= '0; k1_r <= '0;
    end else begin
      if (cmd.wb_en) begin
        case (cmd.op)
          kaf_pkg::OP_ANG, kaf_pkg::OP_KY0:
            angle_r <= kaf_pkg::sat32(40'(angle_r) + rnd_x);
          kaf_pkg::OP_KY1: bias_r <= kaf_pkg::sat32(40'(bias_r) + rnd_x);
          kaf_pkg::OP_P00: p00_r <= kaf_pkg::sat32(40'(p00_r) + rnd_x);
          kaf_pkg::OP_P11: p11_r <= kaf_pkg::sat32(40'(p11_r) + rnd_x);
          kaf_pkg::OP_C00: p00_r <= kaf_pkg::sat32(40'(p00_r) - rnd_x);
          kaf_pkg::OP_C01: p01_r <= kaf_pkg::sat32(40'(p01_r) - rnd_x);
          kaf_pkg::OP_C10: p10_r <= kaf_pkg::sat32(40'(p10_r) - rnd_x);
          kaf_pkg::OP_C11: p11_r <= kaf_pkg::sat32(40'(p11_r) - rnd_x);
          default: ;
        endcase
      end
      if (cmd.do_inner) begin
        p01_r <= kaf_pkg::sat32(40'(p01_r) - 40'(dtp11_r));
        p10_r <= kaf_pkg::sat32(40'(p10_r) - 40'(dtp11_r));
      end
      // Gains default to zero; they stay so when S is not positive.
      if (cmd.do_s) begin
        k0_r <= '0;
        k1_r <= '0;
      end
      if (cmd.div_wait && div_done) begin
        if (cmd.div_k1) k1_r <= div_q;
        else k0_r <= div_q;
      end
    end
  end

  assign div_num = cmd.div_k1 ? p10_r : p00_r;

  kaf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (s_r[31:0]),
    .done  (div_done),
    .quot  (div_q)
  );

  assign stat.div_done = div_done;
  assign stat.s_pos    = !s_sum[33] && (s_sum != 34'sd0);

  assign out_filtered_angle = out_angle_r;
  assign out_bias_estimate  = out_bias_r;

endmodule

>>> hw/rtl/kaf_ctrl.sv
// ----------------------------------------------------------------------------
// kaf_ctrl
// Controller: walks one item through predict, gain and correct steps and
// hands the result to the output register.
// ----------------------------------------------------------------------------
module kaf_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  input  kaf_pkg::stat_t stat,
  output kaf_pkg::cmd_t  cmd
);

  kaf_pkg::state_t state_r, state_nxt;
  kaf_pkg::op_t    op_r, op_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    case (state_r)
      kaf_pkg::ST_IDLE: if (in_valid) state_nxt = kaf_pkg::ST_RATE;
      kaf_pkg::ST_RATE: begin
        state_nxt = kaf_pkg::ST_MUL;
        op_nxt    = kaf_pkg::OP_ANG;
      end
      kaf_pkg::ST_MUL: state_nxt = kaf_pkg::ST_RND;
      kaf_pkg::ST_RND: state_nxt = kaf_pkg::ST_WB;
      kaf_pkg::ST_WB: begin
        state_nxt = kaf_pkg::ST_MUL;
        case (op_r)
          kaf_pkg::OP_ANG:   op_nxt = kaf_pkg::OP_DTP11;
          kaf_pkg::OP_DTP11: state_nxt = kaf_pkg::ST_INNER;
          kaf_pkg::OP_P00:   op_nxt = kaf_pkg::OP_P11;
          kaf_pkg::OP_P11:   state_nxt = kaf_pkg::ST_S;
          kaf_pkg::OP_KY0:   op_nxt = kaf_pkg::OP_KY1;
          kaf_pkg::OP_KY1:   op_nxt = kaf_pkg::OP_C00;
          kaf_pkg::OP_C00:   op_nxt = kaf_pkg::OP_C01;
          kaf_pkg::OP_C01:   op_nxt = kaf_pkg::OP_C10;
          kaf_pkg::OP_C10:   op_nxt = kaf_pkg::OP_C11;
          default:           state_nxt = kaf_pkg::ST_OUT;
        endcase
      end
      kaf_pkg::ST_INNER: begin
        state_nxt = kaf_pkg::ST_MUL;
        op_nxt    = kaf_pkg::OP_P00;
      end
      kaf_pkg::ST_S: state_nxt = stat.s_pos ? kaf_pkg::ST_D0S : kaf_pkg::ST_Y;
      kaf_pkg::ST_D0S: state_nxt = kaf_pkg::ST_D0W;
      kaf_pkg::ST_D0W: if (stat.div_done) state_nxt = kaf_pkg::ST_D1S;
      kaf_pkg::ST_D1S: state_nxt = kaf_pkg::ST_D1W;
      kaf_pkg::ST_D1W: if (stat.div_done) state_nxt = kaf_pkg::ST_Y;
      kaf_pkg::ST_Y: begin
        state_nxt = kaf_pkg::ST_MUL;
        op_nxt    = kaf_pkg::OP_KY0;
      end
      kaf_pkg::ST_OUT: if (out_free) state_nxt = kaf_pkg::ST_IDLE;
      default: state_nxt = kaf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.op        = op_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      kaf_pkg::ST_IDLE:  cmd.load_in = in_valid;
      kaf_pkg::ST_RATE:  cmd.do_rate = 1'b1;
      kaf_pkg::ST_MUL:   cmd.mul_en = 1'b1;
      kaf_pkg::ST_RND:   cmd.rnd_en = 1'b1;
      kaf_pkg::ST_WB:    cmd.wb_en = 1'b1;
      kaf_pkg::ST_INNER: cmd.do_inner = 1'b1;
      kaf_pkg::ST_S:     cmd.do_s = 1'b1;
      kaf_pkg::ST_D0S:   cmd.div_start = 1'b1;
      kaf_pkg::ST_D0W:   cmd.div_wait = 1'b1;
      kaf_pkg::ST_D1S: begin
        cmd.div_start = 1'b1;
        cmd.div_k1    = 1'b1;
      end
      kaf_pkg::ST_D1W: begin
        cmd.div_wait = 1'b1;
        cmd.div_k1   = 1'b1;
      end
      kaf_pkg::ST_Y:     cmd.do_y = 1'b1;
      kaf_pkg::ST_OUT: begin
        if (out_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= kaf_pkg::ST_IDLE;
      op_r        <= kaf_pkg::OP_ANG;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != kaf_pkg::ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

>>> hw/rtl/kalman_angle_filter_top.sv
// ----------------------------------------------------------------------------
// kalman_angle_filter_top
// Two-state Kalman filter (angle and gyro bias) with APB noise registers.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake          Payload
// in_      input      in_valid/in_stall  measured_angle, measured_rate, time_step
// out_     output     out_valid/stall    filtered_angle, bias_estimate
// cfg_     APB slave  psel/penable       noise registers at 0x0, 0x4, 0x8
//
// Work per item: two 31-step gain divisions (only when S is positive) and ten
// multiply, round and write-back steps through the single shared multiplier.
// One item is worked on at a time; the next is accepted once the result sits
// in the output register, even while that register is still stalled.
// Reset clears the filter state to zero and loads the default noise values.
// ----------------------------------------------------------------------------
module kalman_angle_filter_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_measured_angle,
  input  logic signed [31:0] in_measured_rate,
  input  logic        [23:0] in_time_step,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_filtered_angle,
  output logic signed [31:0] out_bias_estimate,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic        [3:0]  cfg_paddr,
  input  logic        [31:0] cfg_pwdata,
  output logic        [31:0] cfg_prdata,
  output logic               cfg_pready
);

  kaf_pkg::cmd_t  cmd;
  kaf_pkg::stat_t stat;
  logic [30:0] qa_r, qb_r, rn_r;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qa_r <= kaf_pkg::QA_RESET;
      qb_r <= kaf_pkg::QB_RESET;
      rn_r <= kaf_pkg::R_RESET;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        kaf_pkg::REG_QA: qa_r <= cfg_pwdata[30:0];
        kaf_pkg::REG_QB: qb_r <= cfg_pwdata[30:0];
        kaf_pkg::REG_R:  rn_r <= cfg_pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      kaf_pkg::REG_QA: cfg_prdata = {1'b0, qa_r};
      kaf_pkg::REG_QB: cfg_prdata = {1'b0, qb_r};
      kaf_pkg::REG_R:  cfg_prdata = {1'b0, rn_r};
      default:         cfg_prdata = '0;
    endcase
  end

  kaf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  kaf_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_measured_angle  (in_measured_angle),
    .in_measured_rate   (in_measured_rate),
    .in_time_step       (in_time_step),
    .qa                 (qa_r),
    .qb                 (qb_r),
    .rn                 (rn_r),
    .out_filtered_angle (out_filtered_angle),
    .out_bias_estimate  (out_bias_estimate)
  );

  // Once an item is taken the block is busy on the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after an item was accepted");

  // A new result only appears after a period of work.
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result raised without the block having been busy");

  // A write to the measurement noise register lands on the next edge.
  a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_wr && cfg_paddr[3:2] == kaf_pkg::REG_R) |=> (rn_r == $past(cfg_pwdata[30:0])))
    else $error("measurement noise register not updated");

endmodule
